// ===== hw/rtl/ibst_pkg.sv =====
package ibst_pkg;

	localparam int KIND_W = 2;
	localparam int ERR_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_LINE = 2'd0,
		KIND_LOOP = 2'd1,
		KIND_COND = 2'd2,
		KIND_SKIP = 2'd3
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 2'd0,
		ERR_INDENT   = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		STK_HOLD = 2'd0,
		STK_PUSH = 2'd1,
		STK_POP  = 2'd2
	} stk_op_t;

endpackage

// ===== hw/rtl/ibst_cmd_if.sv =====
interface ibst_cmd_if #(
	parameter int LEVEL_BITS = 8,
	parameter int ADDR_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic [ibst_pkg::KIND_W-1:0] kind;
	logic [LEVEL_BITS-1:0]       indentation;
	logic [ADDR_BITS-1:0]        line_address;

	modport source (output valid, output kind, output indentation, output line_address,
		input ready);
	modport sink (input valid, input kind, input indentation, input line_address,
		output ready);
endinterface

// ===== hw/rtl/ibst_res_if.sv =====
interface ibst_res_if #(
	parameter int ADDR_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic                       execute;
	logic                       jump;
	logic [ADDR_BITS-1:0]       jump_address;
	logic [ibst_pkg::ERR_W-1:0] error;

	modport source (output valid, output execute, output jump, output jump_address,
		output error, input ready);
	modport sink (input valid, input execute, input jump, input jump_address,
		input error, output ready);
endinterface

// ===== hw/rtl/ibst_cell.sv =====
module ibst_cell #(
	parameter int AW = 16,
	parameter int LW = 9
) (
	input  logic              clk,
	input  ibst_pkg::stk_op_t op,
	input  logic [AW-1:0]     above_start,
	input  logic [LW-1:0]     above_level,
	input  logic              above_loop,
	input  logic [AW-1:0]     below_start,
	input  logic [LW-1:0]     below_level,
	input  logic              below_loop,
	output logic [AW-1:0]     start,
	output logic [LW-1:0]     level,
	output logic              loop
);

	logic [AW-1:0] start_q;
	logic [LW-1:0] level_q;
	logic          loop_q;

	always_ff @(posedge clk) begin
		case (op)
			ibst_pkg::STK_PUSH: begin
				start_q <= above_start;
				level_q <= above_level;
				loop_q  <= above_loop;
			end
			ibst_pkg::STK_POP: begin
				start_q <= below_start;
				level_q <= below_level;
				loop_q  <= below_loop;
			end
			default: begin
				start_q <= start_q;
				level_q <= level_q;
				loop_q  <= loop_q;
			end
		endcase
	end

	assign start = start_q;
	assign level = level_q;
	assign loop  = loop_q;

endmodule

// ===== hw/rtl/ibst_stack.sv =====
module ibst_stack #(
	parameter int DEPTH = 16,
	parameter int AW = 16,
	parameter int LW = 9,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ibst_pkg::stk_op_t op,
	input  logic [AW-1:0]     push_start,
	input  logic [LW-1:0]     push_level,
	input  logic              push_loop,
	output logic [AW-1:0]     top_start,
	output logic [LW-1:0]     top_level,
	output logic              top_loop,
	output logic [CW-1:0]     count
);

	logic [AW-1:0] start_w [DEPTH+1];
	logic [LW-1:0] level_w [DEPTH+1];
	logic          loop_w  [DEPTH+1];
	logic [AW-1:0] start_c [DEPTH];
	logic [LW-1:0] level_c [DEPTH];
	logic          loop_c  [DEPTH];
	logic [CW-1:0] count_q;

	assign start_w[0] = push_start;
	assign level_w[0] = push_level;
	assign loop_w[0]  = push_loop;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			ibst_cell #(.AW(AW), .LW(LW)) u_cell (
				.clk         (clk),
				.op          (op),
				.above_start (start_w[i]),
				.above_level (level_w[i]),
				.above_loop  (loop_w[i]),
				.below_start (start_w[i+2 > DEPTH ? DEPTH : i+2]),
				.below_level (level_w[i+2 > DEPTH ? DEPTH : i+2]),
				.below_loop  (loop_w[i+2 > DEPTH ? DEPTH : i+2]),
				.start       (start_c[i]),
				.level       (level_c[i]),
				.loop        (loop_c[i])
			);
			assign start_w[i+1] = start_c[i];
			assign level_w[i+1] = level_c[i];
			assign loop_w[i+1]  = loop_c[i];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				ibst_pkg::STK_PUSH: count_q <= count_q + CW'(1);
				ibst_pkg::STK_POP:  count_q <= count_q - CW'(1);
				default:            count_q <= count_q;
			endcase
		end
	end

	assign top_start = start_c[0];
	assign top_level = level_c[0];
	assign top_loop  = loop_c[0];
	assign count     = count_q;

endmodule

// ===== hw/rtl/indentation_block_stack_tracker_core.sv =====
// Indentation block stack tracker.
// The cmd channel takes one item per script event: a line start (kind, indentation,
// line_address), an open loop, an open conditional or a skip block. The res channel
// returns exactly one item for each cmd item, in order: execute, jump, jump_address
// and error.
// Open and skip items, skipped lines and lines with no open block produce their result
// in the cycle after acceptance. Any other line walks the block stack, a chain of cells
// that shifts by one entry per cycle. It pops each closed conditional block in turn and
// then loads an execute result; closing a loop block ends the walk in the cycle that
// pops it, with a jump result. The longest walk is a line that closes STACK_DEPTH
// conditional blocks.
// One item is processed at a time, so the next cmd item is taken at the earliest in the
// cycle after the previous result is loaded; cmd.ready is high while the tracker is idle
// and the result register is empty or being drained in the same cycle.
// When res.ready is low, the pending result is held and no new item is accepted.
// Reset empties the block stack, clears the skip level and the current line and
// level, and drops any pending result.
module indentation_block_stack_tracker_core #(
	parameter int STACK_DEPTH = 16,
	parameter int ADDR_BITS = 16,
	parameter int LEVEL_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	ibst_cmd_if.sink cmd,
	ibst_res_if.source res
);

	localparam int LVW = LEVEL_BITS + 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_UNWIND = 2'b10
	} state_t;

	state_t                 state_q;
	logic                   skip_active_q;
	logic [LVW-1:0]         skip_level_q;
	logic [LEVEL_BITS-1:0]  cur_level_q;
	logic [ADDR_BITS-1:0]   cur_line_q;
	logic [LEVEL_BITS-1:0]  lvl_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic                   res_valid_q;
	logic                   res_exec_q;
	logic                   res_jump_q;
	logic [ADDR_BITS-1:0]   res_addr_q;
	ibst_pkg::err_t         res_err_q;

	ibst_pkg::stk_op_t      stk_op;
	logic [ADDR_BITS-1:0]   top_start;
	logic [LVW-1:0]         top_level;
	logic                   top_loop;
	logic [CW-1:0]          count;

	ibst_pkg::kind_t        kind;
	logic                   acc;
	logic                   full;
	logic                   pop_ok;
	logic                   skipped;
	logic [LVW-1:0]         next_level;

	logic                   res_load;
	logic                   res_exec_d;
	logic                   res_jump_d;
	logic [ADDR_BITS-1:0]   res_addr_d;
	ibst_pkg::err_t         res_err_d;

	ibst_stack #(.DEPTH(STACK_DEPTH), .AW(ADDR_BITS), .LW(LVW)) u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (stk_op),
		.push_start (kind == ibst_pkg::KIND_LOOP ? cur_line_q : '0),
		.push_level (next_level),
		.push_loop  (kind == ibst_pkg::KIND_LOOP),
		.top_start  (top_start),
		.top_level  (top_level),
		.top_loop   (top_loop),
		.count      (count)
	);

	assign kind       = ibst_pkg::kind_t'(cmd.kind);
	assign cmd.ready  = (state_q == S_IDLE) && (!res_valid_q || res.ready);
	assign acc        = cmd.valid && cmd.ready;
	assign full       = (count == CW'(STACK_DEPTH));
	assign next_level = LVW'(cur_level_q) + LVW'(1);
	assign skipped    = skip_active_q && (LVW'(cmd.indentation) >= skip_level_q);
	assign pop_ok     = (count != '0) && (LVW'(lvl_q) < top_level);

	always_comb begin
		stk_op     = ibst_pkg::STK_HOLD;
		res_load   = 1'b0;
		res_exec_d = 1'b0;
		res_jump_d = 1'b0;
		res_addr_d = '0;
		res_err_d  = ibst_pkg::ERR_NONE;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (kind)
						ibst_pkg::KIND_LINE: begin
							if (skipped) begin
								res_load = 1'b1;
							end else if (count == '0) begin
								res_load = 1'b1;
								if (cmd.indentation != '0) begin
									res_err_d = ibst_pkg::ERR_INDENT;
								end else begin
									res_exec_d = 1'b1;
								end
							end
						end
						ibst_pkg::KIND_LOOP, ibst_pkg::KIND_COND: begin
							res_load = 1'b1;
							if (full) begin
								res_err_d = ibst_pkg::ERR_OVERFLOW;
							end else begin
								stk_op = ibst_pkg::STK_PUSH;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			S_UNWIND: begin
				if (pop_ok) begin
					stk_op = ibst_pkg::STK_POP;
					if (top_loop) begin
						res_load   = 1'b1;
						res_jump_d = 1'b1;
						res_addr_d = top_start;
					end
				end else begin
					res_load   = 1'b1;
					res_exec_d = 1'b1;
				end
			end
			default: begin
				stk_op = ibst_pkg::STK_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			skip_active_q <= 1'b0;
			skip_level_q  <= '0;
			cur_level_q   <= '0;
			cur_line_q    <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (kind)
							ibst_pkg::KIND_LINE: begin
								cur_level_q <= cmd.indentation;
								if (!skipped) begin
									skip_active_q <= 1'b0;
									if (count == '0) begin
										if (cmd.indentation == '0) begin
											cur_line_q <= cmd.line_address;
										end
									end else begin
										state_q <= S_UNWIND;
									end
								end
							end
							ibst_pkg::KIND_SKIP: begin
								skip_active_q <= 1'b1;
								skip_level_q  <= next_level;
							end
							default: begin
								skip_active_q <= skip_active_q;
							end
						endcase
					end
				end
				S_UNWIND: begin
					if (pop_ok) begin
						if (top_loop) begin
							state_q <= S_IDLE;
						end
					end else begin
						cur_line_q <= addr_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			lvl_q  <= cmd.indentation;
			addr_q <= cmd.line_address;
		end
		if (res_load) begin
			res_exec_q <= res_exec_d;
			res_jump_q <= res_jump_d;
			res_addr_q <= res_addr_d;
			res_err_q  <= res_err_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.execute      = res_exec_q;
	assign res.jump         = res_jump_q;
	assign res.jump_address = res_addr_q;
	assign res.error        = res_err_q;

endmodule

// ===== tb/ibst_checker.sv =====
`timescale 1ns / 1ps

module ibst_checker #(
	parameter int STACK_DEPTH = 16,
	parameter int ADDR_BITS = 16,
	parameter int LEVEL_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	ibst_cmd_if cmd,
	ibst_res_if res,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic                 execute;
		logic                 jump;
		logic [ADDR_BITS-1:0] jump_address;
		ibst_pkg::err_t       error;
	} outcome_t;

	outcome_t outcomes_due[$];

	logic [ADDR_BITS-1:0]  blk_start [STACK_DEPTH];
	logic [LEVEL_BITS:0]   blk_level [STACK_DEPTH];
	logic                  blk_loop [STACK_DEPTH];
	int unsigned           open_blocks;
	logic                  skipping;
	logic [LEVEL_BITS:0]   skip_from;
	logic [LEVEL_BITS-1:0] line_level;
	logic [ADDR_BITS-1:0]  line_addr_last;

	function automatic outcome_t track_item(input ibst_pkg::kind_t k,
		input logic [LEVEL_BITS-1:0] lvl, input logic [ADDR_BITS-1:0] addr);
		outcome_t o;
		logic run;
		logic closed_loop;
		o = '0;
		o.error = ibst_pkg::ERR_NONE;
		case (k)
			ibst_pkg::KIND_LINE: begin
				run = 1'b1;
				line_level = lvl;
				if (skipping && {1'b0, lvl} >= skip_from) begin
					run = 1'b0;
				end else begin
					skipping = 1'b0;
					if (open_blocks == 0) begin
						if (lvl != '0) begin
							o.error = ibst_pkg::ERR_INDENT;
							run = 1'b0;
						end
					end else begin
						closed_loop = 1'b0;
						// Unwinding stops at the first loop block, which turns into a jump.
						while (!closed_loop && open_blocks > 0 &&
							{1'b0, lvl} < blk_level[open_blocks-1]) begin
							open_blocks--;
							if (blk_loop[open_blocks]) begin
								o.jump = 1'b1;
								o.jump_address = blk_start[open_blocks];
								run = 1'b0;
								closed_loop = 1'b1;
							end
						end
					end
				end
				if (run) begin
					o.execute = 1'b1;
					line_addr_last = addr;
				end
			end
			ibst_pkg::KIND_LOOP, ibst_pkg::KIND_COND: begin
				if (open_blocks >= STACK_DEPTH) begin
					o.error = ibst_pkg::ERR_OVERFLOW;
				end else begin
					blk_start[open_blocks] = (k == ibst_pkg::KIND_LOOP) ? line_addr_last : '0;
					blk_level[open_blocks] = {1'b0, line_level} + 1'b1;
					blk_loop[open_blocks] = (k == ibst_pkg::KIND_LOOP);
					open_blocks++;
				end
			end
			default: begin
				skipping = 1'b1;
				skip_from = {1'b0, line_level} + 1'b1;
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			outcomes_due.delete();
			open_blocks = 0;
			skipping = 1'b0;
			skip_from = '0;
			line_level = '0;
			line_addr_last = '0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (outcomes_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result item arrived with none expected", $time);
				end else begin
					want = outcomes_due.pop_front();
					if (res.execute !== want.execute || res.jump !== want.jump ||
						res.jump_address !== want.jump_address || res.error !== want.error) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("%0t: mismatch, expected execute=%0b jump=%0b addr=%h error=%0d,",
								$time, want.execute, want.jump, want.jump_address, want.error);
							$display(" got execute=%0b jump=%0b addr=%h error=%0d",
								res.execute, res.jump, res.jump_address, res.error);
						end
					end
				end
			end
			if (cmd.valid && cmd.ready)
				outcomes_due.push_back(track_item(ibst_pkg::kind_t'(cmd.kind), cmd.indentation,
					cmd.line_address));
			pending <= outcomes_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int STACK_DEPTH = 16;
	localparam int ADDR_BITS = 16;
	localparam int LEVEL_BITS = 8;
	localparam int RANDOM_ITEMS = 1420;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int MAX_LEVEL = (1 << LEVEL_BITS) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic send_burst = 1'b0;
	logic long_hold_req = 1'b0;
	int unsigned fail_count;
	int unsigned pending;

	ibst_cmd_if #(.LEVEL_BITS(LEVEL_BITS), .ADDR_BITS(ADDR_BITS)) cmd ();
	ibst_res_if #(.ADDR_BITS(ADDR_BITS)) res ();

	indentation_block_stack_tracker_core #(
		.STACK_DEPTH(STACK_DEPTH),
		.ADDR_BITS(ADDR_BITS),
		.LEVEL_BITS(LEVEL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res)
	);

	ibst_checker #(
		.STACK_DEPTH(STACK_DEPTH),
		.ADDR_BITS(ADDR_BITS),
		.LEVEL_BITS(LEVEL_BITS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap(input logic burst);
		return burst ? 0 : $urandom_range(0, 5);
	endfunction

	task automatic send_item(input ibst_pkg::kind_t k, input logic [LEVEL_BITS-1:0] lvl,
		input logic [ADDR_BITS-1:0] addr);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			cmd.valid = 1'b0;
			cmd.kind = ibst_pkg::kind_t'($urandom_range(0, 3));
			cmd.indentation = LEVEL_BITS'($urandom);
			cmd.line_address = ADDR_BITS'($urandom);
			repeat (gap) @(negedge clk);
		end
		cmd.valid = 1'b1;
		cmd.kind = k;
		cmd.indentation = lvl;
		cmd.line_address = addr;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
	endtask

	initial begin
		int gap;
		logic burst;
		logic held;
		burst = 1'b0;
		held = 1'b0;
		res.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
			if (long_hold_req && !held) begin
				res.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				held = 1'b1;
			end
			gap = draw_gap(burst);
			if (gap > 0) begin
				res.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res.ready = 1'b1;
			do @(posedge clk); while (!res.valid);
			@(negedge clk);
		end
	end

	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
				idle = 0;
			else
				idle++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		ibst_pkg::kind_t k;
		int last_lvl;
		int pick;
		int storm;
		logic opened;
		logic [LEVEL_BITS-1:0] lvl;
		cmd.valid = 1'b0;
		cmd.kind = ibst_pkg::KIND_LINE;
		cmd.indentation = '0;
		cmd.line_address = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Indented line with nothing open, then a stack filled past its depth.
		send_item(ibst_pkg::KIND_LINE, 8'd7, 16'h0000);
		send_item(ibst_pkg::KIND_LINE, 8'd0, 16'hFFFF);
		repeat (STACK_DEPTH) send_item(ibst_pkg::KIND_COND, 8'd0, 16'h0000);
		send_item(ibst_pkg::KIND_LOOP, 8'd0, 16'h0000);
		send_item(ibst_pkg::KIND_LINE, 8'd0, 16'h0000);
		// A loop whose body is skipped, then closed by a jump.
		send_item(ibst_pkg::KIND_LINE, 8'd0, 16'hFFFF);
		send_item(ibst_pkg::KIND_LOOP, 8'd0, 16'h0000);
		send_item(ibst_pkg::KIND_SKIP, 8'd0, 16'h0000);
		send_item(ibst_pkg::KIND_LINE, 8'd200, 16'h1234);
		send_item(ibst_pkg::KIND_LINE, 8'd0, 16'h4321);
		// A conditional with a much deeper body, closed down to an empty stack.
		send_item(ibst_pkg::KIND_LINE, 8'd0, 16'h5555);
		send_item(ibst_pkg::KIND_COND, 8'd0, 16'h0000);
		send_item(ibst_pkg::KIND_LINE, 8'd255, 16'hAAAA);
		send_item(ibst_pkg::KIND_LOOP, 8'd0, 16'h0000);
		send_item(ibst_pkg::KIND_LINE, 8'd255, 16'h0F0F);
		send_item(ibst_pkg::KIND_LINE, 8'd0, 16'hF0F0);

		last_lvl = 0;
		opened = 1'b0;
		storm = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				long_hold_req = 1'b1;
			if (n % 200 == 100)
				storm = STACK_DEPTH + 1;
			pick = $urandom_range(0, 99);
			if (storm > 0) begin
				storm--;
				k = (pick < 50) ? ibst_pkg::KIND_LOOP : ibst_pkg::KIND_COND;
			end else if (pick < 12) begin
				k = ibst_pkg::KIND_LOOP;
			end else if (pick < 26) begin
				k = ibst_pkg::KIND_COND;
			end else if (pick < 31) begin
				k = ibst_pkg::KIND_SKIP;
			end else begin
				k = ibst_pkg::KIND_LINE;
			end
			if (k == ibst_pkg::KIND_LINE) begin
				pick = $urandom_range(0, 99);
				if (opened && pick < 75)
					lvl = LEVEL_BITS'((last_lvl >= MAX_LEVEL) ? MAX_LEVEL : last_lvl + 1);
				else if (pick < 90)
					lvl = LEVEL_BITS'($urandom_range(0,
						(last_lvl >= MAX_LEVEL) ? MAX_LEVEL : last_lvl + 1));
				else
					lvl = LEVEL_BITS'($urandom_range(0, MAX_LEVEL));
				last_lvl = int'(lvl);
				opened = 1'b0;
			end else begin
				lvl = LEVEL_BITS'($urandom);
				if (k != ibst_pkg::KIND_SKIP)
					opened = 1'b1;
			end
			send_item(k, lvl, ADDR_BITS'($urandom));
		end
		cmd.valid = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
